/* sv/rbc_pkg.sv */
// Shared types, codes and seed constants for the ROM boot checksum block.
package rbc_pkg;

   // Input command codes
   typedef enum logic [0:0] {
      CMD_LOAD = 1'b0,
      CMD_DATA = 1'b1
   } rbc_cmd_type;

   // Boot chip variants
   typedef enum logic [1:0] {
      VAR_6102 = 2'd0,
      VAR_6103 = 2'd1,
      VAR_6105 = 2'd2,
      VAR_6106 = 2'd3
   } rbc_variant_type;

   localparam logic [31:0] SEED_6102 = 32'hF8CA4DDC;
   localparam logic [31:0] SEED_6103 = 32'hA3886759;
   localparam logic [31:0] SEED_6105 = 32'hDF26F436;
   localparam logic [31:0] SEED_6106 = 32'h1FEA617A;

   localparam int unsigned WinDepth   = 64;
   localparam int unsigned WinAddrW   = $clog2(WinDepth);

   typedef struct packed {
      rbc_cmd_type         cmd;
      logic [5:0]          window_index;
      logic [31:0]         word_value;
      logic                last;
   } rbc_req_type;

   typedef struct packed {
      logic [31:0] checksum_high;
      logic [31:0] checksum_low;
   } rbc_rsp_type;

   // Accumulator set handed from the update stage to the final combine
   typedef struct packed {
      logic [31:0] mix;
      logic [31:0] sel;
      logic [31:0] xr;
      logic [31:0] carries;
      logic [31:0] rotsum;
      logic [31:0] sum;
   } rbc_acc_type;

   function automatic logic [31:0] seed_of(rbc_variant_type v);
      logic [31:0] s;
      unique case (v)
         VAR_6102: s = SEED_6102;
         VAR_6103: s = SEED_6103;
         VAR_6105: s = SEED_6105;
         VAR_6106: s = SEED_6106;
         default:  s = SEED_6102;
      endcase
      return s;
   endfunction

endpackage

/* sv/rbc_window.sv */
// Boot window memory and front-end word position counter.
module rbc_window
   import rbc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  rbc_req_type         item,
   output logic [31:0]         win_data
);

   logic [31:0]         mem [WinDepth];
   logic [WinAddrW-1:0] pos_ff;
   logic [WinAddrW-1:0] pos_in;
   logic [31:0]         rdata_ff;

   // Position of the next data word; a last word closes the run
   always_comb begin
      pos_in = pos_ff;
      if (accept && item.cmd == CMD_DATA) begin
         pos_in = item.last ? '0 : pos_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   // Loads write, data words read; both at the transfer, so order is kept
   always_ff @(posedge clock) begin
      if (accept) begin
         if (item.cmd == CMD_LOAD) begin
            mem[item.window_index[WinAddrW-1:0]] <= item.word_value;
         end else begin
            rdata_ff <= mem[pos_ff];
         end
      end
   end

   assign win_data = rdata_ff;

endmodule

/* sv/rbc_accum.sv */
// Accumulator update for one data word per cycle while step is high.
module rbc_accum
   import rbc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            step,
   input  rbc_variant_type variant,
   input  logic [31:0]     word,
   input  logic            last,
   input  logic [31:0]     win_data,
   output rbc_acc_type     acc_next
);

   rbc_acc_type acc_ff;
   rbc_acc_type acc_in;
   rbc_acc_type base;
   logic        active_ff;
   logic        active_in;
   logic [32:0] sum_wide;
   logic [63:0] rot_wide;
   logic [31:0] rot;
   logic [31:0] mix_term;

   // Seed every accumulator at the first word of a run
   always_comb begin
      if (active_ff) begin
         base = acc_ff;
      end else begin
         base.mix     = seed_of(variant);
         base.sel     = seed_of(variant);
         base.xr      = seed_of(variant);
         base.carries = seed_of(variant);
         base.rotsum  = seed_of(variant);
         base.sum     = seed_of(variant);
      end
   end

   // One word's update
   always_comb begin
      sum_wide       = {1'b0, base.sum} + {1'b0, word};
      rot_wide       = {word, word} << word[4:0];
      rot            = rot_wide[63:32];
      acc_in.sum     = sum_wide[31:0];
      acc_in.carries = base.carries + {31'd0, sum_wide[32]};
      acc_in.xr      = base.xr ^ word;
      acc_in.rotsum  = base.rotsum + rot;
      if (base.sel > word) begin
         acc_in.sel = base.sel ^ rot;
      end else begin
         acc_in.sel = base.sel ^ acc_in.sum ^ word;
      end
      mix_term   = (variant == VAR_6105) ? (win_data ^ word) : (acc_in.rotsum ^ word);
      acc_in.mix = base.mix + mix_term;
   end

   assign active_in = step ? !last : active_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         acc_ff    <= '0;
      end else begin
         active_ff <= active_in;
         if (step) begin
            acc_ff <= acc_in;
         end
      end
   end

   assign acc_next = acc_in;

endmodule

/* sv/rbc_combine.sv */
// Final combine of a finished run and the result register.
module rbc_combine
   import rbc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            snap_valid,
   output logic            snap_ready,
   input  rbc_acc_type     snap_acc,
   input  rbc_variant_type variant,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rbc_rsp_type     rsp_data
);

   logic            s2_valid_ff;
   logic            s2_valid_in;
   rbc_acc_type     s2_acc_ff;
   rbc_variant_type s2_var_ff;
   logic            out_valid_ff;
   logic            out_valid_in;
   rbc_rsp_type     out_data_ff;
   rbc_rsp_type     out_data_in;
   logic            out_take;
   logic [31:0]     prod_hi;
   logic [31:0]     prod_lo;

   assign out_take   = !out_valid_ff || rsp_ready;
   assign snap_ready = !s2_valid_ff || out_take;

   // Combine by variant
   always_comb begin
      prod_hi = 32'(s2_acc_ff.sum * s2_acc_ff.carries);
      prod_lo = 32'(s2_acc_ff.rotsum * s2_acc_ff.sel);
      case (s2_var_ff)
         VAR_6103: begin
            out_data_in.checksum_high = (s2_acc_ff.sum ^ s2_acc_ff.carries) + s2_acc_ff.xr;
            out_data_in.checksum_low  = (s2_acc_ff.rotsum ^ s2_acc_ff.sel) + s2_acc_ff.mix;
         end
         VAR_6106: begin
            out_data_in.checksum_high = prod_hi + s2_acc_ff.xr;
            out_data_in.checksum_low  = prod_lo + s2_acc_ff.mix;
         end
         default: begin
            out_data_in.checksum_high = s2_acc_ff.sum ^ s2_acc_ff.carries ^ s2_acc_ff.xr;
            out_data_in.checksum_low  = s2_acc_ff.rotsum ^ s2_acc_ff.sel ^ s2_acc_ff.mix;
         end
      endcase
   end

   // Stage and result valid flags
   always_comb begin
      s2_valid_in = s2_valid_ff;
      if (snap_valid) begin
         s2_valid_in = 1'b1;
      end else if (s2_valid_ff && out_take) begin
         s2_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (s2_valid_ff && out_take) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (snap_valid) begin
         s2_acc_ff <= snap_acc;
         s2_var_ff <= variant;
      end
      if (s2_valid_ff && out_take) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

/* sv/console_rom_boot_checksum.sv */
// Top level of the cartridge ROM boot checksum block.
//
//  channel | direction | ports                          | moves
//  req     | in        | req_valid req_ready req_data   | window load or data word
//  rsp     | out       | rsp_valid rsp_ready rsp_data   | two header checksum words
//  csr     | in        | csr_valid csr_ready csr_data   | boot chip variant
//
// One item per cycle is taken unless a last word waits for the combine stage; a result is
// offered after the input register (loaded at the transfer), combine and result registers.
// The window memory read is issued at the input transfer, so its data is registered with the word.
// Synchronous reset clears the run state, position and variant; window undefined.
// A stalled result backs up only as far as a finished run needs space.
module console_rom_boot_checksum
   import rbc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  rbc_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rbc_rsp_type rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_data
);

   rbc_variant_type variant_ff;
   logic            s1_valid_ff;
   logic            s1_valid_in;
   rbc_req_type     s1_item_ff;
   logic            s1_is_data;
   logic            s1_is_last;
   logic            s1_go;
   logic            accept;
   logic            snap_ready;
   logic [31:0]     win_data;
   rbc_acc_type     acc_next;

   // Variant register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         variant_ff <= VAR_6102;
      end else if (csr_valid && csr_ready) begin
         variant_ff <= rbc_variant_type'(csr_data);
      end
   end

   // Input register and its handshake
   assign s1_is_data = s1_item_ff.cmd == CMD_DATA;
   assign s1_is_last = s1_is_data && s1_item_ff.last;
   assign s1_go      = s1_valid_ff && (!s1_is_last || snap_ready);
   assign req_ready  = !s1_valid_ff || s1_go;
   assign accept     = req_valid && req_ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff <= req_data;
      end
   end

   rbc_window u_window (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .item     (req_data),
      .win_data (win_data)
   );

   rbc_accum u_accum (
      .clock    (clock),
      .reset    (reset),
      .step     (s1_go && s1_is_data),
      .variant  (variant_ff),
      .word     (s1_item_ff.word_value),
      .last     (s1_item_ff.last),
      .win_data (win_data),
      .acc_next (acc_next)
   );

   rbc_combine u_combine (
      .clock      (clock),
      .reset      (reset),
      .snap_valid (s1_go && s1_is_last),
      .snap_ready (snap_ready),
      .snap_acc   (acc_next),
      .variant    (variant_ff),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule
